/* rtl/tad_pkg.sv */
// shared types, codes and helpers for the thumb to arm decompressor
`timescale 1ns / 1ps

package tad_pkg;

  // execution unit codes
  typedef enum logic [3:0] {
    UNIT_NONE     = 4'd0,
    UNIT_DATAPROC = 4'd1,
    UNIT_MULTIPLY = 4'd2,
    UNIT_SINGLE   = 4'd3,
    UNIT_HALFWORD = 4'd4,
    UNIT_BLOCK    = 4'd5,
    UNIT_BRANCH   = 4'd6,
    UNIT_BX       = 4'd7,
    UNIT_SWI      = 4'd8
  } unit_e;

  // thumb format numbers
  localparam logic [4:0] MODE_SHIFT     = 5'd0;
  localparam logic [4:0] MODE_ADDSUB    = 5'd1;
  localparam logic [4:0] MODE_IMM       = 5'd2;
  localparam logic [4:0] MODE_ALU       = 5'd3;
  localparam logic [4:0] MODE_HIREG     = 5'd4;
  localparam logic [4:0] MODE_PC_LOAD   = 5'd5;
  localparam logic [4:0] MODE_REG_OFS   = 5'd6;
  localparam logic [4:0] MODE_SIGN_EXT  = 5'd7;
  localparam logic [4:0] MODE_IMM_OFS   = 5'd8;
  localparam logic [4:0] MODE_HALF      = 5'd9;
  localparam logic [4:0] MODE_SP_LDST   = 5'd10;
  localparam logic [4:0] MODE_LOAD_ADDR = 5'd11;
  localparam logic [4:0] MODE_SP_ADJ    = 5'd12;
  localparam logic [4:0] MODE_PUSH_POP  = 5'd13;
  localparam logic [4:0] MODE_MULTI     = 5'd14;
  localparam logic [4:0] MODE_COND_BR   = 5'd15;
  localparam logic [4:0] MODE_SWI       = 5'd16;
  localparam logic [4:0] MODE_BRANCH    = 5'd17;

  // arm data processing opcodes
  localparam logic [3:0] OPC_AND = 4'h0;
  localparam logic [3:0] OPC_EOR = 4'h1;
  localparam logic [3:0] OPC_SUB = 4'h2;
  localparam logic [3:0] OPC_RSB = 4'h3;
  localparam logic [3:0] OPC_ADD = 4'h4;
  localparam logic [3:0] OPC_ADC = 4'h5;
  localparam logic [3:0] OPC_SBC = 4'h6;
  localparam logic [3:0] OPC_TST = 4'h8;
  localparam logic [3:0] OPC_CMP = 4'hA;
  localparam logic [3:0] OPC_CMN = 4'hB;
  localparam logic [3:0] OPC_ORR = 4'hC;
  localparam logic [3:0] OPC_MOV = 4'hD;
  localparam logic [3:0] OPC_BIC = 4'hE;
  localparam logic [3:0] OPC_MVN = 4'hF;

  // thumb alu group operations
  localparam logic [3:0] ALU_AND = 4'd0;
  localparam logic [3:0] ALU_EOR = 4'd1;
  localparam logic [3:0] ALU_LSL = 4'd2;
  localparam logic [3:0] ALU_LSR = 4'd3;
  localparam logic [3:0] ALU_ASR = 4'd4;
  localparam logic [3:0] ALU_ADC = 4'd5;
  localparam logic [3:0] ALU_SBC = 4'd6;
  localparam logic [3:0] ALU_ROR = 4'd7;
  localparam logic [3:0] ALU_TST = 4'd8;
  localparam logic [3:0] ALU_NEG = 4'd9;
  localparam logic [3:0] ALU_CMP = 4'd10;
  localparam logic [3:0] ALU_CMN = 4'd11;
  localparam logic [3:0] ALU_ORR = 4'd12;
  localparam logic [3:0] ALU_MUL = 4'd13;
  localparam logic [3:0] ALU_BIC = 4'd14;

  // high register operations
  localparam logic [1:0] HI_ADD = 2'd0;
  localparam logic [1:0] HI_CMP = 2'd1;
  localparam logic [1:0] HI_MOV = 2'd2;
  localparam logic [1:0] HI_BX  = 2'd3;

  // immediate group operations
  localparam logic [1:0] IMM_MOV = 2'd0;
  localparam logic [1:0] IMM_CMP = 2'd1;
  localparam logic [1:0] IMM_ADD = 2'd2;

  // shift types
  localparam logic [1:0] SHT_LSL = 2'd0;
  localparam logic [1:0] SHT_LSR = 2'd1;
  localparam logic [1:0] SHT_ASR = 2'd2;
  localparam logic [1:0] SHT_ROR = 2'd3;

  // condition codes
  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_CS = 4'd2;
  localparam logic [3:0] CC_CC = 4'd3;
  localparam logic [3:0] CC_MI = 4'd4;
  localparam logic [3:0] CC_PL = 4'd5;
  localparam logic [3:0] CC_VS = 4'd6;
  localparam logic [3:0] CC_VC = 4'd7;
  localparam logic [3:0] CC_HI = 4'd8;
  localparam logic [3:0] CC_LS = 4'd9;
  localparam logic [3:0] CC_GE = 4'd10;
  localparam logic [3:0] CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12;
  localparam logic [3:0] CC_LE = 4'd13;
  localparam logic [3:0] CC_AL = 4'd14;

  localparam logic [3:0] COND_ALWAYS = 4'hE;
  localparam logic [3:0] REG_SP      = 4'd13;
  localparam logic [3:0] REG_PC      = 4'd15;

  // decoded item between the decode and assembly stages
  typedef struct packed {
    logic        valid;
    logic [4:0]  mode;
    logic [15:0] tw;
    unit_e       unit;
  } dec_t;

  // arm data processing word
  function automatic logic [31:0] dp_word(input logic imm, input logic [3:0] opc,
                                          input logic s, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic [11:0] op2);
    dp_word = {COND_ALWAYS, 2'b00, imm, opc, s, rn, rd, op2};
  endfunction

  // condition check against n z c v
  function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
    logic n, z, c, v;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    case (cond)
      CC_EQ:   cond_pass = z;
      CC_NE:   cond_pass = !z;
      CC_CS:   cond_pass = c;
      CC_CC:   cond_pass = !c;
      CC_MI:   cond_pass = n;
      CC_PL:   cond_pass = !n;
      CC_VS:   cond_pass = v;
      CC_VC:   cond_pass = !v;
      CC_HI:   cond_pass = c && !z;
      CC_LS:   cond_pass = !c || z;
      CC_GE:   cond_pass = (n == v);
      CC_LT:   cond_pass = (n != v);
      CC_GT:   cond_pass = !z && (n == v);
      CC_LE:   cond_pass = z || (n != v);
      CC_AL:   cond_pass = 1'b1;
      default: cond_pass = 1'b0;
    endcase
  endfunction

endpackage

/* rtl/tad_decode.sv */
// input register stage and unit classification stage
`timescale 1ns / 1ps

module tad_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [4:0]       mode_i,
  input  logic [15:0]      thumb_word_i,
  input  logic [3:0]       flags_i,
  output tad_pkg::dec_t    dec_o
);
  import tad_pkg::*;

  logic        s1_valid_q;
  logic [4:0]  s1_mode_q;
  logic [15:0] s1_tw_q;
  logic [3:0]  s1_flags_q;
  unit_e       unit_d;
  logic        s2_valid_q;
  logic [4:0]  s2_mode_q;
  logic [15:0] s2_tw_q;
  unit_e       s2_unit_q;

  // stage one: capture the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_mode_q  <= mode_i;
      s1_tw_q    <= thumb_word_i;
      s1_flags_q <= flags_i;
    end
  end

  // pick the execution unit, condition folded in for conditional branches
  always_comb begin
    case (s1_mode_q)
      MODE_SHIFT, MODE_ADDSUB, MODE_IMM, MODE_LOAD_ADDR, MODE_SP_ADJ:
        unit_d = UNIT_DATAPROC;
      MODE_ALU:
        unit_d = (s1_tw_q[9:6] == ALU_MUL) ? UNIT_MULTIPLY : UNIT_DATAPROC;
      MODE_HIREG:
        unit_d = (s1_tw_q[9:8] == HI_BX) ? UNIT_BX : UNIT_DATAPROC;
      MODE_PC_LOAD, MODE_REG_OFS, MODE_IMM_OFS, MODE_SP_LDST:
        unit_d = UNIT_SINGLE;
      MODE_SIGN_EXT, MODE_HALF:
        unit_d = UNIT_HALFWORD;
      MODE_PUSH_POP, MODE_MULTI:
        unit_d = UNIT_BLOCK;
      MODE_COND_BR:
        unit_d = cond_pass(s1_tw_q[11:8], s1_flags_q) ? UNIT_BRANCH : UNIT_NONE;
      MODE_SWI:
        unit_d = UNIT_SWI;
      MODE_BRANCH:
        unit_d = UNIT_BRANCH;
      default:
        unit_d = UNIT_NONE;
    endcase
  end

  // stage two register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_mode_q <= s1_mode_q;
      s2_tw_q   <= s1_tw_q;
      s2_unit_q <= unit_d;
    end
  end

  assign dec_o = '{valid: s2_valid_q, mode: s2_mode_q, tw: s2_tw_q, unit: s2_unit_q};

endmodule

/* rtl/tad_assemble.sv */
// arm word assembly and output register stage
`timescale 1ns / 1ps

module tad_assemble (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tad_pkg::dec_t    dec_i,
  output logic             valid_o,
  output tad_pkg::unit_e   unit_o,
  output logic [31:0]      word_o
);
  import tad_pkg::*;

  logic        valid_q;
  unit_e       unit_q;
  logic [31:0] word_q;
  logic [31:0] word_d;

  // build the arm word from the thumb fields
  always_comb begin
    logic [15:0] t;
    logic [2:0]  r0, r3, r6, r8;
    logic [4:0]  off5;
    logic [7:0]  imm8;
    logic        b11, b10, ld, byte_sel;
    logic [1:0]  sh;
    logic [3:0]  hd, hs;
    logic [6:0]  ofs7;
    logic [15:0] list;
    logic [31:0] w;
    t        = dec_i.tw;
    r0       = t[2:0];
    r3       = t[5:3];
    r6       = t[8:6];
    r8       = t[10:8];
    off5     = t[10:6];
    imm8     = t[7:0];
    b11      = t[11];
    b10      = t[10];
    ld       = b11 | b10;
    sh       = ld ? {b10, b11} : 2'b01;
    hd       = {t[7], t[2:0]};
    hs       = t[6:3];
    byte_sel = t[12];
    ofs7     = byte_sel ? {2'b00, off5} : {off5, 2'b00};
    list     = {b11 & t[8], ~b11 & t[8], 6'b0, imm8};
    w        = '0;
    case (dec_i.mode)
      MODE_SHIFT:
        w = dp_word(1'b0, OPC_MOV, 1'b1, 4'd0, {1'b0, r0}, {off5, t[12:11], 2'b00, r3});
      MODE_ADDSUB:
        w = dp_word(b10, t[9] ? OPC_SUB : OPC_ADD, 1'b1, {1'b0, r3}, {1'b0, r0},
                    {9'd0, r6});
      MODE_IMM: begin
        case (t[12:11])
          IMM_MOV: w = dp_word(1'b1, OPC_MOV, 1'b1, 4'd0, {1'b0, r8}, {4'd0, imm8});
          IMM_CMP: w = dp_word(1'b1, OPC_CMP, 1'b1, {1'b0, r8}, 4'd0, {4'd0, imm8});
          IMM_ADD: w = dp_word(1'b1, OPC_ADD, 1'b1, {1'b0, r8}, {1'b0, r8}, {4'd0, imm8});
          default: w = dp_word(1'b1, OPC_SUB, 1'b1, {1'b0, r8}, {1'b0, r8}, {4'd0, imm8});
        endcase
      end
      MODE_ALU: begin
        // rd is r0, rs is r3
        case (t[9:6])
          ALU_AND: w = dp_word(1'b0, OPC_AND, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          ALU_EOR: w = dp_word(1'b0, OPC_EOR, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          ALU_LSL: w = dp_word(1'b0, OPC_MOV, 1'b1, 4'd0, {1'b0, r0},
                               {1'b0, r3, 1'b0, SHT_LSL, 2'b10, r0});
          ALU_LSR: w = dp_word(1'b0, OPC_MOV, 1'b1, 4'd0, {1'b0, r0},
                               {1'b0, r3, 1'b0, SHT_LSR, 2'b10, r0});
          ALU_ASR: w = dp_word(1'b0, OPC_MOV, 1'b1, 4'd0, {1'b0, r0},
                               {1'b0, r3, 1'b0, SHT_ASR, 2'b10, r0});
          ALU_ADC: w = dp_word(1'b0, OPC_ADC, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          ALU_SBC: w = dp_word(1'b0, OPC_SBC, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          ALU_ROR: w = dp_word(1'b0, OPC_MOV, 1'b1, 4'd0, {1'b0, r0},
                               {1'b0, r3, 1'b0, SHT_ROR, 2'b10, r0});
          ALU_TST: w = dp_word(1'b0, OPC_TST, 1'b1, {1'b0, r0}, 4'd0, {9'd0, r3});
          ALU_NEG: w = dp_word(1'b1, OPC_RSB, 1'b1, {1'b0, r3}, {1'b0, r0}, 12'd0);
          ALU_CMP: w = dp_word(1'b0, OPC_CMP, 1'b1, {1'b0, r0}, 4'd0, {9'd0, r3});
          ALU_CMN: w = dp_word(1'b0, OPC_CMN, 1'b1, {1'b0, r0}, 4'd0, {9'd0, r3});
          ALU_ORR: w = dp_word(1'b0, OPC_ORR, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          ALU_MUL: w = {COND_ALWAYS, 7'b0000000, 1'b1, 1'b0, r0, 4'd0, 1'b0, r0,
                        4'h9, 1'b0, r3};
          ALU_BIC: w = dp_word(1'b0, OPC_BIC, 1'b1, {1'b0, r0}, {1'b0, r0}, {9'd0, r3});
          default: w = dp_word(1'b0, OPC_MVN, 1'b1, 4'd0, {1'b0, r0}, {9'd0, r3});
        endcase
      end
      MODE_HIREG: begin
        case (t[9:8])
          HI_ADD:  w = dp_word(1'b0, OPC_ADD, 1'b0, hd, hd, {8'd0, hs});
          HI_CMP:  w = dp_word(1'b0, OPC_CMP, 1'b1, hd, 4'd0, {8'd0, hs});
          HI_MOV:  w = dp_word(1'b0, OPC_MOV, 1'b0, 4'd0, hd, {8'd0, hs});
          default: w = {28'd0, hs};
        endcase
      end
      MODE_PC_LOAD:
        w = {12'hE59, REG_PC, 1'b0, r8, 2'b00, imm8, 2'b00};
      MODE_REG_OFS:
        w = {8'hE7, 1'b1, b10, 1'b0, b11, 1'b0, r3, 1'b0, r0, 9'd0, r6};
      MODE_SIGN_EXT:
        w = {8'hE1, 3'b100, ld, 1'b0, r3, 1'b0, r0, 4'h0, 1'b1, sh, 1'b1, 1'b0, r6};
      MODE_IMM_OFS:
        w = {8'hE5, 1'b1, byte_sel, 1'b0, b11, 1'b0, r3, 1'b0, r0, 5'd0, ofs7};
      MODE_HALF:
        // halfword offset scaled by two
        w = {8'hE1, 3'b110, b11, 1'b0, r3, 1'b0, r0, 2'b00, off5[4:3], 4'hB,
             off5[2:0], 1'b0};
      MODE_SP_LDST:
        w = {8'hE5, 3'b100, b11, REG_SP, 1'b0, r8, 2'b00, imm8, 2'b00};
      MODE_LOAD_ADDR:
        w = dp_word(1'b1, OPC_ADD, 1'b0, b11 ? REG_SP : REG_PC, {1'b0, r8}, {4'hF, imm8});
      MODE_SP_ADJ:
        w = dp_word(1'b1, t[7] ? OPC_SUB : OPC_ADD, 1'b0, REG_SP, REG_SP,
                    {4'hF, 1'b0, t[6:0]});
      MODE_PUSH_POP:
        w = {COND_ALWAYS, 3'b100, ~b11, b11, 1'b0, 1'b1, b11, REG_SP, list};
      MODE_MULTI:
        w = {8'hE8, 3'b101, b11, 1'b0, r8, 8'h00, imm8};
      MODE_COND_BR:
        w = {8'hEA, {16{imm8[7]}}, imm8};
      MODE_SWI:
        w = {24'd0, imm8};
      MODE_BRANCH:
        w = {8'hEA, {13{t[10]}}, t[10:0]};
      default:
        w = '0;
    endcase
    // failed condition and unknown formats give a zero word
    word_d = (dec_i.unit == UNIT_NONE) ? 32'd0 : w;
  end

  // output register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_i.valid) begin
      unit_q <= dec_i.unit;
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign unit_o  = unit_q;
  assign word_o  = word_q;

endmodule

/* rtl/thumb_to_arm_decompressor_core.sv */
// top level of the thumb to arm instruction decompressor
`timescale 1ns / 1ps

// Translates one 16-bit Thumb instruction per clock into the equivalent ARM word and
// an execution unit code. Raise start with the format number, the instruction and the
// current NZCV flags; busy is never asserted, so a new beat is taken on every cycle.
// The result appears on valid_o once the beat has passed the input register, the
// classification stage and the word assembly stage, for exactly one cycle, and must be
// captured then since there is no back-pressure on the result side. A conditional
// branch whose condition fails, and an unknown format, report unit none with word 0.
module thumb_to_arm_decompressor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  mode_i,
  input  logic [15:0] thumb_word_i,
  input  logic [3:0]  flags_i,
  output logic        valid_o,
  output logic [3:0]  unit_class_o,
  output logic [31:0] arm_word_o
);
  import tad_pkg::*;

  dec_t  dec;
  unit_e unit;
  logic  take;

  // the pipeline never stalls
  assign busy = 1'b0;
  assign take = start && !busy;

  // input capture and unit classification
  tad_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .mode_i       (mode_i),
    .thumb_word_i (thumb_word_i),
    .flags_i      (flags_i),
    .dec_o        (dec)
  );

  // word assembly and output register
  tad_assemble u_assemble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dec_i   (dec),
    .valid_o (valid_o),
    .unit_o  (unit),
    .word_o  (arm_word_o)
  );

  assign unit_class_o = unit;

endmodule

/* rtl/tad_checker.sv */
// port level checks for the decompressor core, bound to the top level
`timescale 1ns / 1ps

module tad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [3:0]  unit_class_o,
  input logic [31:0] arm_word_o
);
  import tad_pkg::*;

  // every accepted beat gives a result on valid_o
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("accepted beat gave no result after three cycles");

  // no result without a matching earlier beat
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 3))
    else $error("result without a matching input beat");

  // unit none always carries a zero word
  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && unit_class_o == UNIT_NONE) |-> (arm_word_o == 32'd0))
    else $error("unit none with non-zero word");

  // bx carries only a register number
  a_bx_reg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && unit_class_o == UNIT_BX) |-> (arm_word_o[31:4] == 28'd0))
    else $error("bx word wider than a register number");

  // swi carries only the comment byte
  a_swi_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && unit_class_o == UNIT_SWI) |-> (arm_word_o[31:8] == 24'd0))
    else $error("swi word wider than the comment byte");

endmodule

bind thumb_to_arm_decompressor_core tad_checker u_tad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .unit_class_o (unit_class_o),
  .arm_word_o   (arm_word_o)
);

/* bench/tb_thumb_to_arm_decompressor_core.sv */
// self-checking bench for the thumb to arm decompressor core
`timescale 1ns / 1ps

module tb_thumb_to_arm_decompressor_core;
  import tad_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BEATS = 1750;
  localparam int QUIET_FIRST  = 700;
  localparam int QUIET_LAST   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;

  // format numbers past the last defined one
  localparam logic [4:0] MODE_FIRST_UNKNOWN = 5'd18;
  localparam logic [4:0] MODE_LAST          = 5'd31;

  // fixed arm encodings that the translated fields are laid over
  localparam logic [31:0] LDR_PC_BASE    = 32'hE5900000;
  localparam logic [31:0] LDST_REG_BASE  = 32'hE7800000;
  localparam logic [31:0] LDST_SH_BASE   = 32'hE1800090;
  localparam logic [31:0] LDST_IMM_BASE  = 32'hE5800000;
  localparam logic [31:0] LDST_HALF_BASE = 32'hE1C000B0;
  localparam logic [31:0] PUSH_POP_BASE  = 32'hE8000000;
  localparam logic [31:0] LDM_STM_BASE   = 32'hE8A00000;
  localparam logic [31:0] BRANCH_BASE    = 32'hEA000000;
  localparam logic [3:0]  MUL_MARK       = 4'b1001;

  typedef struct packed {
    unit_e       unit;
    logic [31:0] word;
  } arm_result_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] tw;
    logic [3:0]  nzcv;
    logic        known;
    arm_result_t want;
  } stim_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [4:0]  mode_i       = '0;
  logic [15:0] thumb_word_i = '0;
  logic [3:0]  flags_i      = '0;
  logic        valid_o;
  logic [3:0]  unit_class_o;
  logic [31:0] arm_word_o;

  arm_result_t pending_arm_q[$];
  stim_row_t   directed_q[$];
  int          error_count = 0;
  int          cycle_count = 0;

  thumb_to_arm_decompressor_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .thumb_word_i (thumb_word_i),
    .flags_i      (flags_i),
    .valid_o      (valid_o),
    .unit_class_o (unit_class_o),
    .arm_word_o   (arm_word_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // arm data processing word, condition always
  function automatic logic [31:0] arm_dataproc(input logic imm, input logic [3:0] opc,
                                               input logic s, input logic [3:0] rn,
                                               input logic [3:0] rd, input logic [11:0] op2);
    arm_dataproc = {COND_ALWAYS, 2'b00, imm, opc, s, rn, rd, op2};
  endfunction

  // operand two for a shift by register
  function automatic logic [11:0] reg_shift_op2(input logic [3:0] rs, input logic [1:0] sht,
                                                input logic [3:0] rd);
    reg_shift_op2 = {rs, 1'b0, sht, 1'b1, rd};
  endfunction

  // branch condition against n z c v
  function automatic logic branch_taken(input logic [3:0] cond, input logic [3:0] nzcv);
    logic n, z, c, v;
    {n, z, c, v} = nzcv;
    case (cond)
      CC_EQ:   branch_taken = z;
      CC_NE:   branch_taken = !z;
      CC_CS:   branch_taken = c;
      CC_CC:   branch_taken = !c;
      CC_MI:   branch_taken = n;
      CC_PL:   branch_taken = !n;
      CC_VS:   branch_taken = v;
      CC_VC:   branch_taken = !v;
      CC_HI:   branch_taken = c && !z;
      CC_LS:   branch_taken = !c || z;
      CC_GE:   branch_taken = (n == v);
      CC_LT:   branch_taken = (n != v);
      CC_GT:   branch_taken = !z && (n == v);
      CC_LE:   branch_taken = z || (n != v);
      CC_AL:   branch_taken = 1'b1;
      default: branch_taken = 1'b0;
    endcase
  endfunction

  // expected arm word and unit for one thumb instruction
  function automatic arm_result_t decompress_thumb(input logic [4:0] m, input logic [15:0] tw,
                                                   input logic [3:0] nzcv);
    arm_result_t res;
    logic [3:0]  r0, r3, r6, r8, hd, hs;
    logic [4:0]  off5;
    logic [7:0]  imm8;
    logic [5:0]  half_ofs;
    logic [15:0] reg_list;
    logic        b10, b11;
    r0       = {1'b0, tw[2:0]};
    r3       = {1'b0, tw[5:3]};
    r6       = {1'b0, tw[8:6]};
    r8       = {1'b0, tw[10:8]};
    off5     = tw[10:6];
    imm8     = tw[7:0];
    b10      = tw[10];
    b11      = tw[11];
    hd       = {tw[7], tw[2:0]};
    hs       = tw[6:3];
    half_ofs = {off5, 1'b0};
    reg_list = {8'd0, imm8};
    res.unit = UNIT_NONE;
    res.word = '0;
    case (m)
      MODE_SHIFT: begin
        res.unit = UNIT_DATAPROC;
        res.word = arm_dataproc(1'b0, OPC_MOV, 1'b1, 4'd0, r0,
                                {off5, tw[12:11], 1'b0, r3});
      end
      MODE_ADDSUB: begin
        res.unit = UNIT_DATAPROC;
        res.word = arm_dataproc(b10, tw[9] ? OPC_SUB : OPC_ADD, 1'b1, r3, r0, {8'd0, r6});
      end
      MODE_IMM: begin
        res.unit = UNIT_DATAPROC;
        case (tw[12:11])
          IMM_MOV: res.word = arm_dataproc(1'b1, OPC_MOV, 1'b1, 4'd0, r8, {4'd0, imm8});
          IMM_CMP: res.word = arm_dataproc(1'b1, OPC_CMP, 1'b1, r8, 4'd0, {4'd0, imm8});
          IMM_ADD: res.word = arm_dataproc(1'b1, OPC_ADD, 1'b1, r8, r8, {4'd0, imm8});
          default: res.word = arm_dataproc(1'b1, OPC_SUB, 1'b1, r8, r8, {4'd0, imm8});
        endcase
      end
      MODE_ALU: begin
        // rd is r0, rs is r3
        res.unit = UNIT_DATAPROC;
        case (tw[9:6])
          ALU_AND: res.word = arm_dataproc(1'b0, OPC_AND, 1'b1, r0, r0, {8'd0, r3});
          ALU_EOR: res.word = arm_dataproc(1'b0, OPC_EOR, 1'b1, r0, r0, {8'd0, r3});
          ALU_LSL: res.word = arm_dataproc(1'b0, OPC_MOV, 1'b1, 4'd0, r0,
                                           reg_shift_op2(r3, SHT_LSL, r0));
          ALU_LSR: res.word = arm_dataproc(1'b0, OPC_MOV, 1'b1, 4'd0, r0,
                                           reg_shift_op2(r3, SHT_LSR, r0));
          ALU_ASR: res.word = arm_dataproc(1'b0, OPC_MOV, 1'b1, 4'd0, r0,
                                           reg_shift_op2(r3, SHT_ASR, r0));
          ALU_ADC: res.word = arm_dataproc(1'b0, OPC_ADC, 1'b1, r0, r0, {8'd0, r3});
          ALU_SBC: res.word = arm_dataproc(1'b0, OPC_SBC, 1'b1, r0, r0, {8'd0, r3});
          ALU_ROR: res.word = arm_dataproc(1'b0, OPC_MOV, 1'b1, 4'd0, r0,
                                           reg_shift_op2(r3, SHT_ROR, r0));
          ALU_TST: res.word = arm_dataproc(1'b0, OPC_TST, 1'b1, r0, 4'd0, {8'd0, r3});
          ALU_NEG: res.word = arm_dataproc(1'b1, OPC_RSB, 1'b1, r3, r0, 12'd0);
          ALU_CMP: res.word = arm_dataproc(1'b0, OPC_CMP, 1'b1, r0, 4'd0, {8'd0, r3});
          ALU_CMN: res.word = arm_dataproc(1'b0, OPC_CMN, 1'b1, r0, 4'd0, {8'd0, r3});
          ALU_ORR: res.word = arm_dataproc(1'b0, OPC_ORR, 1'b1, r0, r0, {8'd0, r3});
          ALU_MUL: begin
            res.unit = UNIT_MULTIPLY;
            res.word = {COND_ALWAYS, 7'd0, 1'b1, r0, 4'd0, r0, MUL_MARK, r3};
          end
          ALU_BIC: res.word = arm_dataproc(1'b0, OPC_BIC, 1'b1, r0, r0, {8'd0, r3});
          default: res.word = arm_dataproc(1'b0, OPC_MVN, 1'b1, 4'd0, r0, {8'd0, r3});
        endcase
      end
      MODE_HIREG: begin
        res.unit = UNIT_DATAPROC;
        case (tw[9:8])
          HI_ADD:  res.word = arm_dataproc(1'b0, OPC_ADD, 1'b0, hd, hd, {8'd0, hs});
          HI_CMP:  res.word = arm_dataproc(1'b0, OPC_CMP, 1'b1, hd, 4'd0, {8'd0, hs});
          HI_MOV:  res.word = arm_dataproc(1'b0, OPC_MOV, 1'b0, 4'd0, hd, {8'd0, hs});
          default: begin
            res.unit = UNIT_BX;
            res.word = {28'd0, hs};
          end
        endcase
      end
      MODE_PC_LOAD: begin
        res.unit = UNIT_SINGLE;
        res.word = LDR_PC_BASE;
        res.word[19:16] = REG_PC;
        res.word[15:12] = r8;
        res.word[11:0]  = {2'b00, imm8, 2'b00};
      end
      MODE_REG_OFS: begin
        res.unit = UNIT_SINGLE;
        res.word = LDST_REG_BASE;
        res.word[22]    = b10;
        res.word[20]    = b11;
        res.word[19:16] = r3;
        res.word[15:12] = r0;
        res.word[3:0]   = r6;
      end
      MODE_SIGN_EXT: begin
        // plain halfword store when neither bit is set
        res.unit = UNIT_HALFWORD;
        res.word = LDST_SH_BASE;
        res.word[20]    = b11 | b10;
        res.word[19:16] = r3;
        res.word[15:12] = r0;
        res.word[6:5]   = (b11 | b10) ? {b10, b11} : 2'b01;
        res.word[3:0]   = r6;
      end
      MODE_IMM_OFS: begin
        // word offsets are scaled to bytes, byte offsets are not
        res.unit = UNIT_SINGLE;
        res.word = LDST_IMM_BASE;
        res.word[22]    = tw[12];
        res.word[20]    = b11;
        res.word[19:16] = r3;
        res.word[15:12] = r0;
        res.word[11:0]  = tw[12] ? {7'd0, off5} : {5'd0, off5, 2'b00};
      end
      MODE_HALF: begin
        res.unit = UNIT_HALFWORD;
        res.word = LDST_HALF_BASE;
        res.word[20]    = b11;
        res.word[19:16] = r3;
        res.word[15:12] = r0;
        res.word[11:8]  = {2'b00, half_ofs[5:4]};
        res.word[3:0]   = half_ofs[3:0];
      end
      MODE_SP_LDST: begin
        res.unit = UNIT_SINGLE;
        res.word = LDST_IMM_BASE;
        res.word[20]    = b11;
        res.word[19:16] = REG_SP;
        res.word[15:12] = r8;
        res.word[11:0]  = {2'b00, imm8, 2'b00};
      end
      MODE_LOAD_ADDR: begin
        res.unit = UNIT_DATAPROC;
        res.word = arm_dataproc(1'b1, OPC_ADD, 1'b0, b11 ? REG_SP : REG_PC, r8,
                                {4'hF, imm8});
      end
      MODE_SP_ADJ: begin
        res.unit = UNIT_DATAPROC;
        res.word = arm_dataproc(1'b1, tw[7] ? OPC_SUB : OPC_ADD, 1'b0, REG_SP, REG_SP,
                                {4'hF, 1'b0, tw[6:0]});
      end
      MODE_PUSH_POP: begin
        // extra register is pc on pop, lr on push
        if (tw[8]) begin
          if (b11) reg_list[15] = 1'b1;
          else reg_list[14] = 1'b1;
        end
        res.unit = UNIT_BLOCK;
        res.word = PUSH_POP_BASE;
        res.word[24]    = !b11;
        res.word[23]    = b11;
        res.word[21]    = 1'b1;
        res.word[20]    = b11;
        res.word[19:16] = REG_SP;
        res.word[15:0]  = reg_list;
      end
      MODE_MULTI: begin
        res.unit = UNIT_BLOCK;
        res.word = LDM_STM_BASE;
        res.word[20]    = b11;
        res.word[19:16] = r8;
        res.word[15:0]  = reg_list;
      end
      MODE_COND_BR: begin
        if (branch_taken(tw[11:8], nzcv)) begin
          res.unit = UNIT_BRANCH;
          res.word = BRANCH_BASE;
          res.word[23:0] = {{16{imm8[7]}}, imm8};
        end
      end
      MODE_SWI: begin
        res.unit = UNIT_SWI;
        res.word = {24'd0, imm8};
      end
      MODE_BRANCH: begin
        res.unit = UNIT_BRANCH;
        res.word = BRANCH_BASE;
        res.word[23:0] = {{13{tw[10]}}, tw[10:0]};
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t row(input logic [4:0] m, input logic [15:0] tw,
                                    input logic [3:0] nzcv, input logic known,
                                    input unit_e u, input logic [31:0] w);
    stim_row_t r;
    r.mode      = m;
    r.tw        = tw;
    r.nzcv      = nzcv;
    r.known     = known;
    r.want.unit = u;
    r.want.word = w;
    return r;
  endfunction

  // one input beat, with an optional idle gap in front of it
  task automatic issue_beat(input stim_row_t r, input bit allow_idle);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(99) < 15) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      // junk on the fields while start is low
      start        <= 1'b0;
      mode_i       <= 5'($urandom);
      thumb_word_i <= 16'($urandom);
      flags_i      <= 4'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= r.mode;
    thumb_word_i <= r.tw;
    flags_i      <= r.nzcv;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (r.known) pending_arm_q.push_back(r.want);
    else pending_arm_q.push_back(decompress_thumb(r.mode, r.tw, r.nzcv));
  endtask

  // compare each result beat with the oldest expected word
  always @(posedge clk_i) begin : check_results
    arm_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_arm_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none got unit %0d word %08h",
                 $time, unit_class_o, arm_word_o);
      end else begin
        want = pending_arm_q.pop_front();
        if (unit_class_o !== want.unit) begin
          error_count++;
          $display("%0t: unit_class expected %0d got %0d", $time, want.unit,
                   unit_class_o);
        end
        if (arm_word_o !== want.word) begin
          error_count++;
          $display("%0t: arm_word expected %08h got %08h", $time, want.word, arm_word_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("thumb_to_arm_decompressor_core: mismatch");
      $finish;
    end
  end

  initial begin : run_stimulus
    stim_row_t r;
    logic [4:0] m;

    // directed rows, fixed results only where they are obvious
    directed_q.push_back(row(MODE_SHIFT, 16'h0000, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SHIFT, 16'h1FFF, 4'hF, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_ADDSUB, 16'h1FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_IMM, 16'h3FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_ALU, 16'h4340, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_ALU, 16'h4240, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_ALU, 16'h43FF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_HIREG, 16'h4400, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    // bx with h1 set, h1 has no effect
    directed_q.push_back(row(MODE_HIREG, 16'h47F8, 4'h0, 1'b1, UNIT_BX, 32'h0000000F));
    directed_q.push_back(row(MODE_PC_LOAD, 16'h4FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_REG_OFS, 16'h5FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SIGN_EXT, 16'h5200, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SIGN_EXT, 16'h5FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_IMM_OFS, 16'h7FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_IMM_OFS, 16'h6FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_HALF, 16'h8FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SP_LDST, 16'h9FFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_LOAD_ADDR, 16'hAFFF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SP_ADJ, 16'hB0FF, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    // pop of pc alone, and an empty register list
    directed_q.push_back(row(MODE_PUSH_POP, 16'hBD00, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_MULTI, 16'hC000, 4'h0, 1'b0, UNIT_NONE, 32'h0));
    // condition always with the most negative offset, condition never
    directed_q.push_back(row(MODE_COND_BR, 16'hDE80, 4'h0, 1'b1, UNIT_BRANCH, 32'hEAFFFF80));
    directed_q.push_back(row(MODE_COND_BR, 16'hDF7F, 4'hF, 1'b1, UNIT_NONE, 32'h0));
    directed_q.push_back(row(MODE_SWI, 16'hDFFF, 4'h0, 1'b1, UNIT_SWI, 32'h000000FF));
    directed_q.push_back(row(MODE_BRANCH, 16'hE400, 4'h0, 1'b1, UNIT_BRANCH, 32'hEAFFFC00));
    // unknown format
    directed_q.push_back(row(MODE_LAST, 16'hFFFF, 4'hF, 1'b1, UNIT_NONE, 32'h0));

    // reset once at the start
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) issue_beat(directed_q[i], 1'b1);

    // random beats, mostly defined formats, with a stretch of back to back beats
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(99) < 90) m = 5'($urandom_range(MODE_SHIFT, MODE_BRANCH));
      else m = 5'($urandom_range(MODE_FIRST_UNKNOWN, MODE_LAST));
      r = row(m, 16'($urandom), 4'($urandom), 1'b0, UNIT_NONE, 32'h0);
      issue_beat(r, !(i >= QUIET_FIRST && i < QUIET_LAST));
    end
    start <= 1'b0;

    // drain
    while (pending_arm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_arm_q.size() == 0) begin
      $display("thumb_to_arm_decompressor_core: match");
    end else begin
      $display("thumb_to_arm_decompressor_core: mismatch");
    end
    $finish;
  end

endmodule
